[src/tfsr_pkg.sv]
// ----------------------------------------------------------------------------
// Tile map fine scroll renderer package
// Shared constants, command and register index codes for the renderer.
// ----------------------------------------------------------------------------
package tfsr_pkg;

   // Default geometry of the map and graphics store
   localparam int MAP_WIDTH_DEF   = 64;
   localparam int MAP_HEIGHT_DEF  = 16;
   localparam int NUM_PLANES_DEF  = 6;
   localparam int TILE_COUNT_DEF  = 16;

   // Screen limits checked on render requests
   localparam int WORDS_PER_ROW = 20;
   localparam int SCREEN_LINES  = 256;

   // Tile geometry
   localparam int TILE_PX   = 16;
   localparam int PIX_ROW_W = 4;

   // Field widths
   localparam int CMD_W     = 2;
   localparam int CELL_X_W  = 6;
   localparam int CELL_Y_W  = 4;
   localparam int TILE_NUM_W = 4;
   localparam int PLANE_W   = 3;
   localparam int WORD_W    = 16;
   localparam int SROW_W    = 8;
   localparam int SCOL_W    = 5;
   localparam int SCROLL_X_W = 10;
   localparam int SCROLL_Y_W = 8;
   localparam int FINE_W    = 4;
   localparam int CSR_IDX_W = 1;

   // Coarse column sum (scroll_x / 16 + column + 1) and tile row index ranges
   localparam int COL_SUM_W       = 7;
   localparam int COL_SUM_ENTRIES = 1 << COL_SUM_W;
   localparam int WORLD_Y_W       = SROW_W + 1;
   localparam int ROW_IDX_W       = WORLD_Y_W - PIX_ROW_W;
   localparam int ROW_IDX_ENTRIES = 1 << ROW_IDX_W;
   localparam int TILE_IDX_ENTRIES = 1 << TILE_NUM_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_MAP_WRITE = 2'd0,
      CMD_GFX_WRITE = 2'd1,
      CMD_RENDER    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCROLL_X = 1'd0,
      REG_SCROLL_Y = 1'd1
   } reg_index_type;

endpackage

[src/tilemap_fine_scroll_renderer_unit.sv]
// ----------------------------------------------------------------------------
// Tile map fine scroll renderer
// Wrapping tile map plus planar tile graphics store, rendering one scrolled
// 16-pixel bitplane word per render request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per beat: map cell write, graphics word write
//   or render. Only render beats produce an rsp_* beat; writes return nothing.
//   csr_* sets scroll_x / scroll_y; write it only while the pipe is empty.
// Pipeline and throughput:
//   A render beat goes through the stage 1, 2 and 3 registers and the output
//   register to rsp_*. The block takes one request beat per cycle unless
//   rsp_ready holds the pipe. Stage 1 decodes; then map read (two columns),
//   graphics read (two words), then the shift/merge into the output register.
// Ordering:
//   Map and graphics writes land in the same stage that reads that memory,
//   so every render sees exactly the writes accepted before it.
// Reset:
//   Clears the scroll registers and all pipeline valids. Map and graphics
//   contents are undefined until written; no clearing pass runs.
// Stall:
//   When rsp_ready is low the output register holds; earlier stages keep
//   filling bubbles and req_ready drops only once the whole pipe is full.
// ----------------------------------------------------------------------------
module tilemap_fine_scroll_renderer_unit #(
   parameter int MAP_WIDTH   = tfsr_pkg::MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT  = tfsr_pkg::MAP_HEIGHT_DEF,
   parameter int NUM_PLANES  = tfsr_pkg::NUM_PLANES_DEF,
   parameter int TILE_COUNT  = tfsr_pkg::TILE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tfsr_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tfsr_pkg::CELL_X_W-1:0]   req_cell_x,
   input  logic [tfsr_pkg::CELL_Y_W-1:0]   req_cell_y,
   input  logic [tfsr_pkg::TILE_NUM_W-1:0] req_cell_tile,
   input  logic [tfsr_pkg::TILE_NUM_W-1:0] req_tile_number,
   input  logic [tfsr_pkg::PLANE_W-1:0]    req_plane,
   input  logic [tfsr_pkg::PIX_ROW_W-1:0]  req_tile_row,
   input  logic [tfsr_pkg::WORD_W-1:0]     req_graphics_word,
   input  logic [tfsr_pkg::SROW_W-1:0]     req_screen_row,
   input  logic [tfsr_pkg::SCOL_W-1:0]     req_screen_col,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tfsr_pkg::WORD_W-1:0]     rsp_pixel_word,
   output logic [tfsr_pkg::PLANE_W-1:0]    rsp_out_plane,
   output logic [tfsr_pkg::SROW_W-1:0]     rsp_out_row,
   output logic [tfsr_pkg::SCOL_W-1:0]     rsp_out_col,
   // configuration
   input  logic                            csr_we,
   input  logic [tfsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfsr_pkg::SCROLL_X_W-1:0] csr_wdata
);

   localparam int COL_W     = $clog2(MAP_WIDTH);
   localparam int ROW_W     = $clog2(MAP_HEIGHT);
   localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int TILE_W    = $clog2(TILE_COUNT);
   localparam int TP_W      = $clog2(TILE_COUNT * NUM_PLANES);
   localparam int GFX_DEPTH = TILE_COUNT * NUM_PLANES * tfsr_pkg::TILE_PX;
   localparam int GFX_AW    = TP_W + tfsr_pkg::PIX_ROW_W;
   localparam int CHK_W     = 12;

   // ---------------------------------------------------------------------
   // Constant wrap tables
   // ---------------------------------------------------------------------
   logic [COL_W-1:0]  col_wrap_tbl  [tfsr_pkg::COL_SUM_ENTRIES];
   logic [ROW_W-1:0]  row_wrap_tbl  [tfsr_pkg::ROW_IDX_ENTRIES];
   logic [TILE_W-1:0] tile_wrap_tbl [tfsr_pkg::TILE_IDX_ENTRIES];

   for (genvar g = 0; g < tfsr_pkg::COL_SUM_ENTRIES; g++) begin : g_col_tbl
      assign col_wrap_tbl[g] = COL_W'(g % MAP_WIDTH);
   end
   for (genvar g = 0; g < tfsr_pkg::ROW_IDX_ENTRIES; g++) begin : g_row_tbl
      assign row_wrap_tbl[g] = ROW_W'(g % MAP_HEIGHT);
   end
   for (genvar g = 0; g < tfsr_pkg::TILE_IDX_ENTRIES; g++) begin : g_tile_tbl
      assign tile_wrap_tbl[g] = TILE_W'(g % TILE_COUNT);
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [tfsr_pkg::SCROLL_X_W-1:0] scroll_x_ff;
   logic [tfsr_pkg::SCROLL_Y_W-1:0] scroll_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tfsr_pkg::REG_SCROLL_X: scroll_x_ff <= csr_wdata;
            tfsr_pkg::REG_SCROLL_Y: scroll_y_ff <= csr_wdata[tfsr_pkg::SCROLL_Y_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic out_free, s3_free, s2_free, s1_free;
   logic s3_move, s2_move, s1_move, accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s3_move   = s3_valid_ff && out_free;
   assign s2_move   = s2_valid_ff && s3_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign accept    = req_valid && s1_free;
   assign req_ready = s1_free;

   // ---------------------------------------------------------------------
   // Stage 1: decode, wrap rows and columns
   // ---------------------------------------------------------------------
   logic                              is_map_wr, is_gfx_wr, is_render;
   logic                              map_in_range, gfx_in_range, render_ok;
   logic [tfsr_pkg::WORLD_Y_W-1:0]    world_y;
   logic [tfsr_pkg::COL_SUM_W-1:0]    col_sum_a, col_sum_b;
   logic [ROW_W-1:0]                  map_row;

   assign is_map_wr = (req_cmd == tfsr_pkg::CMD_MAP_WRITE);
   assign is_gfx_wr = (req_cmd == tfsr_pkg::CMD_GFX_WRITE);
   assign is_render = (req_cmd == tfsr_pkg::CMD_RENDER);

   assign map_in_range = (CHK_W'(req_cell_x) < CHK_W'(MAP_WIDTH)) &&
                         (CHK_W'(req_cell_y) < CHK_W'(MAP_HEIGHT));
   assign gfx_in_range = (CHK_W'(req_tile_number) < CHK_W'(TILE_COUNT)) &&
                         (CHK_W'(req_plane) < CHK_W'(NUM_PLANES));
   assign render_ok    = (CHK_W'(req_plane) < CHK_W'(NUM_PLANES)) &&
                         (CHK_W'(req_screen_row) < CHK_W'(tfsr_pkg::SCREEN_LINES)) &&
                         (CHK_W'(req_screen_col) < CHK_W'(tfsr_pkg::WORDS_PER_ROW));

   assign world_y   = tfsr_pkg::WORLD_Y_W'(scroll_y_ff) +
                      tfsr_pkg::WORLD_Y_W'(req_screen_row);
   assign col_sum_a = tfsr_pkg::COL_SUM_W'(scroll_x_ff[tfsr_pkg::SCROLL_X_W-1:tfsr_pkg::FINE_W]) +
                      tfsr_pkg::COL_SUM_W'(req_screen_col);
   assign col_sum_b = col_sum_a + tfsr_pkg::COL_SUM_W'(1);
   assign map_row   = row_wrap_tbl[world_y[tfsr_pkg::WORLD_Y_W-1:tfsr_pkg::PIX_ROW_W]];

   logic                              s1_render_ff, s1_ok_ff, s1_map_we_ff, s1_gfx_we_ff;
   logic [ROW_W-1:0]                  s1_row_ff;
   logic [COL_W-1:0]                  s1_col_a_ff, s1_col_b_ff;
   logic [tfsr_pkg::TILE_NUM_W-1:0]   s1_cell_tile_ff, s1_tile_number_ff;
   logic [tfsr_pkg::PLANE_W-1:0]      s1_plane_ff;
   logic [tfsr_pkg::PIX_ROW_W-1:0]    s1_pix_row_ff;
   logic [tfsr_pkg::WORD_W-1:0]       s1_gword_ff;
   logic [tfsr_pkg::FINE_W-1:0]       s1_fine_ff;
   logic [tfsr_pkg::SROW_W-1:0]       s1_srow_ff;
   logic [tfsr_pkg::SCOL_W-1:0]       s1_scol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_render_ff      <= is_render;
         s1_ok_ff          <= is_render && render_ok;
         s1_map_we_ff      <= is_map_wr && map_in_range;
         s1_gfx_we_ff      <= is_gfx_wr && gfx_in_range;
         // map writes share the row/column address path with renders
         s1_row_ff         <= is_map_wr ? ROW_W'(req_cell_y) : map_row;
         s1_col_a_ff       <= is_map_wr ? COL_W'(req_cell_x) : col_wrap_tbl[col_sum_a];
         s1_col_b_ff       <= col_wrap_tbl[col_sum_b];
         s1_cell_tile_ff   <= req_cell_tile;
         s1_tile_number_ff <= req_tile_number;
         s1_plane_ff       <= req_plane;
         s1_pix_row_ff     <= is_gfx_wr ? req_tile_row :
                              world_y[tfsr_pkg::PIX_ROW_W-1:0];
         s1_gword_ff       <= req_graphics_word;
         s1_fine_ff        <= scroll_x_ff[tfsr_pkg::FINE_W-1:0];
         s1_srow_ff        <= req_screen_row;
         s1_scol_ff        <= req_screen_col;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: tile map access
   // ---------------------------------------------------------------------
   logic [tfsr_pkg::TILE_NUM_W-1:0] map_mem [MAP_DEPTH];
   logic [MAP_AW-1:0]               map_addr_a, map_addr_b, map_row_base;

   assign map_row_base = MAP_AW'(s1_row_ff) * MAP_AW'(MAP_WIDTH);
   assign map_addr_a   = map_row_base + MAP_AW'(s1_col_a_ff);
   assign map_addr_b   = map_row_base + MAP_AW'(s1_col_b_ff);

   logic                              s2_render_ff, s2_ok_ff, s2_gfx_we_ff;
   logic [tfsr_pkg::TILE_NUM_W-1:0]   s2_tile_a_ff, s2_tile_b_ff, s2_tile_number_ff;
   logic [tfsr_pkg::PLANE_W-1:0]      s2_plane_ff;
   logic [tfsr_pkg::PIX_ROW_W-1:0]    s2_pix_row_ff;
   logic [tfsr_pkg::WORD_W-1:0]       s2_gword_ff;
   logic [tfsr_pkg::FINE_W-1:0]       s2_fine_ff;
   logic [tfsr_pkg::SROW_W-1:0]       s2_srow_ff;
   logic [tfsr_pkg::SCOL_W-1:0]       s2_scol_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (s1_map_we_ff) begin
            map_mem[map_addr_a] <= s1_cell_tile_ff;
         end
         s2_tile_a_ff <= map_mem[map_addr_a];
         s2_tile_b_ff <= map_mem[map_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_render_ff      <= s1_render_ff;
         s2_ok_ff          <= s1_ok_ff;
         s2_gfx_we_ff      <= s1_gfx_we_ff;
         s2_tile_number_ff <= s1_tile_number_ff;
         s2_plane_ff       <= s1_plane_ff;
         s2_pix_row_ff     <= s1_pix_row_ff;
         s2_gword_ff       <= s1_gword_ff;
         s2_fine_ff        <= s1_fine_ff;
         s2_srow_ff        <= s1_srow_ff;
         s2_scol_ff        <= s1_scol_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: tile graphics access
   // ---------------------------------------------------------------------
   logic [tfsr_pkg::WORD_W-1:0] gfx_mem [GFX_DEPTH];
   logic [TILE_W-1:0]           tile_sel_a, tile_sel_b;
   logic [TP_W-1:0]             tp_a, tp_b;
   logic [GFX_AW-1:0]           gfx_addr_a, gfx_addr_b;

   // stored tile numbers wrap on the tile count; writes use the given tile
   assign tile_sel_a = s2_gfx_we_ff ? TILE_W'(s2_tile_number_ff) : tile_wrap_tbl[s2_tile_a_ff];
   assign tile_sel_b = tile_wrap_tbl[s2_tile_b_ff];
   assign tp_a       = TP_W'(tile_sel_a) * TP_W'(NUM_PLANES) + TP_W'(s2_plane_ff);
   assign tp_b       = TP_W'(tile_sel_b) * TP_W'(NUM_PLANES) + TP_W'(s2_plane_ff);
   assign gfx_addr_a = {tp_a, s2_pix_row_ff};
   assign gfx_addr_b = {tp_b, s2_pix_row_ff};

   logic                              s3_render_ff, s3_ok_ff;
   logic [tfsr_pkg::WORD_W-1:0]       s3_word_a_ff, s3_word_b_ff;
   logic [tfsr_pkg::PLANE_W-1:0]      s3_plane_ff;
   logic [tfsr_pkg::FINE_W-1:0]       s3_fine_ff;
   logic [tfsr_pkg::SROW_W-1:0]       s3_srow_ff;
   logic [tfsr_pkg::SCOL_W-1:0]       s3_scol_ff;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         if (s2_gfx_we_ff) begin
            gfx_mem[gfx_addr_a] <= s2_gword_ff;
         end
         s3_word_a_ff <= gfx_mem[gfx_addr_a];
         s3_word_b_ff <= gfx_mem[gfx_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_render_ff <= s2_render_ff;
         s3_ok_ff     <= s2_ok_ff;
         s3_plane_ff  <= s2_plane_ff;
         s3_fine_ff   <= s2_fine_ff;
         s3_srow_ff   <= s2_srow_ff;
         s3_scol_ff   <= s2_scol_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: fine shift merge and output register
   // ---------------------------------------------------------------------
   logic [tfsr_pkg::WORD_W-1:0]  shl_word, shr_word, merged_in;
   logic [tfsr_pkg::FINE_W:0]    shr_amt;

   assign shr_amt   = (tfsr_pkg::FINE_W + 1)'(tfsr_pkg::TILE_PX) -
                      (tfsr_pkg::FINE_W + 1)'(s3_fine_ff);
   assign shl_word  = s3_word_a_ff << s3_fine_ff;
   assign shr_word  = s3_word_b_ff >> shr_amt;
   assign merged_in = !s3_ok_ff ? '0 :
                      (s3_fine_ff == '0) ? s3_word_a_ff : (shl_word | shr_word);

   logic [tfsr_pkg::WORD_W-1:0]  pixel_word_ff;
   logic [tfsr_pkg::PLANE_W-1:0] out_plane_ff;
   logic [tfsr_pkg::SROW_W-1:0]  out_row_ff;
   logic [tfsr_pkg::SCOL_W-1:0]  out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         // drop write beats here; only renders leave the block
         rsp_valid_ff <= s3_valid_ff && s3_render_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         pixel_word_ff <= merged_in;
         out_plane_ff  <= s3_plane_ff;
         out_row_ff    <= s3_srow_ff;
         out_col_ff    <= s3_scol_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_word = pixel_word_ff;
   assign rsp_out_plane  = out_plane_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;

endmodule
